>>> hdl/tick_driven_virtual_timer_bank_assert.svh
// Assertion macros shared by the timer bank RTL.
// Needs signals named clock and reset in the module that uses them.
`ifndef TICK_DRIVEN_VIRTUAL_TIMER_BANK_ASSERT_SVH
`define TICK_DRIVEN_VIRTUAL_TIMER_BANK_ASSERT_SVH

// same-cycle implication
`define TDVT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TDVT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/tdvt_pkg.sv
// Types and codes for the tick driven virtual timer bank.
// No dependencies.
package tdvt_pkg;

   localparam logic [2:0] CMD_TICK    = 3'd0;
   localparam logic [2:0] CMD_START   = 3'd1;
   localparam logic [2:0] CMD_STOP    = 3'd2;
   localparam logic [2:0] CMD_RESTART = 3'd3;
   localparam logic [2:0] CMD_QUERY   = 3'd4;

   localparam logic KIND_EXPIRY = 1'b0;
   localparam logic KIND_QUERY  = 1'b1;

   localparam int CHAN_W = 4;

   typedef struct packed {
      logic [2:0]        command;
      logic [CHAN_W-1:0] channel;
      logic [31:0]       period;
      logic              one_shot;
   } req_type;

   typedef struct packed {
      logic              kind;
      logic [CHAN_W-1:0] channel_out;
      logic [31:0]       elapsed;
      logic              last;
   } rsp_type;

   typedef enum logic [1:0] {
      QOP_NONE,
      QOP_INSERT,
      QOP_REMOVE,
      QOP_POP
   } qop_code_type;

   typedef struct packed {
      qop_code_type      code;
      logic [CHAN_W-1:0] ch;
   } qop_type;

endpackage

>>> hdl/tdvt_cell.sv
// One slot of the deadline-ordered queue.
// Depends on tdvt_pkg.
module tdvt_cell #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  tdvt_pkg::qop_type            op,
   input  logic [COUNT_WIDTH-1:0]       new_dl,
   input  logic                         found_in,
   output logic                         found_out,
   input  logic                         left_v,
   input  logic [tdvt_pkg::CHAN_W-1:0]  left_ch,
   input  logic [COUNT_WIDTH-1:0]       left_dl,
   input  logic                         right_v,
   input  logic [tdvt_pkg::CHAN_W-1:0]  right_ch,
   input  logic [COUNT_WIDTH-1:0]       right_dl,
   output logic                         v,
   output logic [tdvt_pkg::CHAN_W-1:0]  ch,
   output logic [COUNT_WIDTH-1:0]       dl
);

   localparam logic [COUNT_WIDTH-1:0] HALF =
      COUNT_WIDTH'((64'(1) << (COUNT_WIDTH - 1)) - 64'(1));

   logic                        v_ff, v_in;
   logic [tdvt_pkg::CHAN_W-1:0] ch_ff, ch_in;
   logic [COUNT_WIDTH-1:0]      dl_ff, dl_in;
   logic [COUNT_WIDTH-1:0]      wrap_gap;
   logic                        not_earlier;
   logic                        hit;

   assign wrap_gap    = dl_ff - new_dl;
   assign not_earlier = v_ff && (wrap_gap < HALF);
   assign hit         = v_ff && (ch_ff == op.ch);

   always_comb begin
      v_in      = v_ff;
      ch_in     = ch_ff;
      dl_in     = dl_ff;
      found_out = found_in;
      case (op.code)
         tdvt_pkg::QOP_INSERT: begin
            found_out = found_in || !v_ff || not_earlier;
            if (found_in) begin
               // make room: take the left neighbour's entry
               v_in  = left_v;
               ch_in = left_ch;
               dl_in = left_dl;
            end else if (!v_ff || not_earlier) begin
               v_in  = 1'b1;
               ch_in = op.ch;
               dl_in = new_dl;
            end
         end
         tdvt_pkg::QOP_REMOVE: begin
            found_out = found_in || hit;
            if (found_in || hit) begin
               v_in  = right_v;
               ch_in = right_ch;
               dl_in = right_dl;
            end
         end
         tdvt_pkg::QOP_POP: begin
            v_in  = right_v;
            ch_in = right_ch;
            dl_in = right_dl;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
      ch_ff <= ch_in;
      dl_ff <= dl_in;
   end

   assign v  = v_ff;
   assign ch = ch_ff;
   assign dl = dl_ff;

endmodule

>>> hdl/tdvt_queue.sv
// Row of queue cells; slot 0 is the head.
// Depends on tdvt_pkg and tdvt_cell.
module tdvt_queue #(
   parameter int NUM_TIMERS  = 16,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  tdvt_pkg::qop_type            op,
   input  logic [COUNT_WIDTH-1:0]       new_dl,
   output logic                         head_v,
   output logic [tdvt_pkg::CHAN_W-1:0]  head_ch,
   output logic [COUNT_WIDTH-1:0]       head_dl,
   output logic                         full
);

   logic                        v   [NUM_TIMERS];
   logic [tdvt_pkg::CHAN_W-1:0] chs [NUM_TIMERS];
   logic [COUNT_WIDTH-1:0]      dls [NUM_TIMERS];
   logic                        found [NUM_TIMERS+1];

   assign found[0] = 1'b0;

   for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
      logic                        lv, rv;
      logic [tdvt_pkg::CHAN_W-1:0] lch, rch;
      logic [COUNT_WIDTH-1:0]      ldl, rdl;

      if (i == 0) begin : g_first
         assign lv  = 1'b0;
         assign lch = '0;
         assign ldl = '0;
      end else begin : g_mid_l
         assign lv  = v[i-1];
         assign lch = chs[i-1];
         assign ldl = dls[i-1];
      end

      if (i == NUM_TIMERS - 1) begin : g_last
         assign rv  = 1'b0;
         assign rch = '0;
         assign rdl = '0;
      end else begin : g_mid_r
         assign rv  = v[i+1];
         assign rch = chs[i+1];
         assign rdl = dls[i+1];
      end

      tdvt_cell #(
         .COUNT_WIDTH (COUNT_WIDTH)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .op        (op),
         .new_dl    (new_dl),
         .found_in  (found[i]),
         .found_out (found[i+1]),
         .left_v    (lv),
         .left_ch   (lch),
         .left_dl   (ldl),
         .right_v   (rv),
         .right_ch  (rch),
         .right_dl  (rdl),
         .v         (v[i]),
         .ch        (chs[i]),
         .dl        (dls[i])
      );
   end

   assign head_v  = v[0];
   assign head_ch = chs[0];
   assign head_dl = dls[0];
   assign full    = v[NUM_TIMERS-1];

endmodule

>>> hdl/tick_driven_virtual_timer_bank.sv
// Top level of the tick driven virtual timer bank: command sequencer,
// per-channel registers, due stack and the queue. Depends on tdvt_pkg,
// tdvt_queue and tick_driven_virtual_timer_bank_assert.svh.
//
//   channel   direction   handshake           payload
//   req_      in          req_valid/stall     tdvt_pkg::req_type
//   rsp_      out         rsp_valid/stall     tdvt_pkg::rsp_type
//
// Start and restart pass through the arm state for the queue insert; stop
// acts from idle. A query waits on the result register. A tick pulls each
// due entry off the queue head, then sends one report per entry, passing
// through the arm state when the channel re-arms. At most one queue
// operation is issued a cycle. Reset is synchronous and empties the queue
// at once. A stalled result holds its register; the sequencer waits for it.
`include "tick_driven_virtual_timer_bank_assert.svh"

module tick_driven_virtual_timer_bank #(
   parameter int NUM_TIMERS  = 16,
   parameter int COUNT_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tdvt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tdvt_pkg::rsp_type rsp_data
);

   localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CNT_W = $clog2(NUM_TIMERS + 1);
   localparam logic [31:0] MAX_PERIOD = 32'(64'(1) << (COUNT_WIDTH - 1));

   typedef enum logic [2:0] {
      S_IDLE,
      S_POP,
      S_EMIT,
      S_ARM,
      S_QRY
   } state_type;

   state_type                   state_ff, state_in;
   logic [COUNT_WIDTH-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]            due_n_ff, due_n_in;
   logic [tdvt_pkg::CHAN_W-1:0] pend_ch_ff, pend_ch_in;
   logic [COUNT_WIDTH-1:0]      pend_dl_ff, pend_dl_in;
   logic                        q_ok_ff, q_ok_in;
   logic [COUNT_WIDTH-1:0]      q_rem_ff, q_rem_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   tdvt_pkg::rsp_type           rsp_data_ff, rsp_data_in;

   logic [COUNT_WIDTH-1:0]      deadline_ff [NUM_TIMERS];
   logic [COUNT_WIDTH-1:0]      period_ff   [NUM_TIMERS];
   logic                        single_ff   [NUM_TIMERS];
   logic                        armed_ff    [NUM_TIMERS];
   logic [tdvt_pkg::CHAN_W-1:0] due_ff      [NUM_TIMERS];

   logic                        dl_we, cfg_we, armed_we, armed_wval, due_we;
   logic [IDX_W-1:0]            dl_widx, armed_widx;
   logic [COUNT_WIDTH-1:0]      dl_wdata, per_wdata;

   logic                        accept, out_free, ch_ok;
   logic [IDX_W-1:0]            req_idx, pend_idx, top_idx;
   logic [CNT_W-1:0]            top_n;
   logic [tdvt_pkg::CHAN_W-1:0] top_ch;
   logic [31:0]                 per_clamp;

   tdvt_pkg::qop_type           qop;
   logic [COUNT_WIDTH-1:0]      qop_dl;
   logic                        head_v, q_full;
   logic [tdvt_pkg::CHAN_W-1:0] head_ch;
   logic [COUNT_WIDTH-1:0]      head_dl;

   tdvt_queue #(
      .NUM_TIMERS  (NUM_TIMERS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .op      (qop),
      .new_dl  (qop_dl),
      .head_v  (head_v),
      .head_ch (head_ch),
      .head_dl (head_dl),
      .full    (q_full)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign ch_ok     = ({28'd0, req_data.channel} < 32'(NUM_TIMERS));
   assign req_idx   = IDX_W'(req_data.channel);
   assign pend_idx  = IDX_W'(pend_ch_ff);
   assign top_n     = due_n_ff - CNT_W'(1);
   assign top_idx   = top_n[IDX_W-1:0];
   assign top_ch    = due_ff[top_idx];

   always_comb begin
      per_clamp = (req_data.period == 32'd0) ? 32'd1 : req_data.period;
      if (per_clamp > MAX_PERIOD) begin
         per_clamp = MAX_PERIOD;
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      due_n_in     = due_n_ff;
      pend_ch_in   = pend_ch_ff;
      pend_dl_in   = pend_dl_ff;
      q_ok_in      = q_ok_ff;
      q_rem_in     = q_rem_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      qop          = '{code: tdvt_pkg::QOP_NONE, ch: '0};
      qop_dl       = pend_dl_ff;
      dl_we        = 1'b0;
      dl_widx      = req_idx;
      dl_wdata     = count_ff + COUNT_WIDTH'(per_clamp);
      cfg_we       = 1'b0;
      per_wdata    = COUNT_WIDTH'(per_clamp);
      armed_we     = 1'b0;
      armed_wval   = 1'b0;
      armed_widx   = req_idx;
      due_we       = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_data.command) inside
                  tdvt_pkg::CMD_TICK: begin
                     count_in = count_ff + COUNT_WIDTH'(1);
                     state_in = S_POP;
                  end
                  tdvt_pkg::CMD_START: begin
                     if (ch_ok && !armed_ff[req_idx]) begin
                        cfg_we     = 1'b1;
                        dl_we      = 1'b1;
                        pend_ch_in = req_data.channel;
                        pend_dl_in = dl_wdata;
                        state_in   = S_ARM;
                     end
                  end
                  tdvt_pkg::CMD_STOP, tdvt_pkg::CMD_RESTART: begin
                     if (ch_ok && armed_ff[req_idx]) begin
                        qop = '{code: tdvt_pkg::QOP_REMOVE, ch: req_data.channel};
                        if (req_data.command == tdvt_pkg::CMD_RESTART) begin
                           dl_we      = 1'b1;
                           dl_wdata   = count_ff + period_ff[req_idx];
                           pend_ch_in = req_data.channel;
                           pend_dl_in = dl_wdata;
                           state_in   = S_ARM;
                        end else begin
                           armed_we = 1'b1;
                        end
                     end
                  end
                  tdvt_pkg::CMD_QUERY: begin
                     q_ok_in    = ch_ok && armed_ff[req_idx];
                     q_rem_in   = deadline_ff[req_idx] - count_ff;
                     pend_ch_in = req_data.channel;
                     state_in   = S_QRY;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_QRY: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.kind         = tdvt_pkg::KIND_QUERY;
               rsp_data_in.channel_out  = pend_ch_ff;
               rsp_data_in.elapsed      = q_ok_ff ?
                  32'(period_ff[pend_idx] - q_rem_ff) : 32'd0;
               rsp_data_in.last         = 1'b1;
               state_in                 = S_IDLE;
            end
         end
         S_POP: begin
            // drain every entry due at the new count off the head
            if (head_v && (head_dl == count_ff)) begin
               due_we   = 1'b1;
               due_n_in = due_n_ff + CNT_W'(1);
               qop      = '{code: tdvt_pkg::QOP_POP, ch: '0};
            end else if (due_n_ff == '0) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.kind        = tdvt_pkg::KIND_EXPIRY;
               rsp_data_in.channel_out = top_ch;
               rsp_data_in.elapsed     = 32'd0;
               rsp_data_in.last        = (due_n_ff == CNT_W'(1));
               due_n_in                = top_n;
               armed_we                = 1'b1;
               armed_widx              = IDX_W'(top_ch);
               if (!single_ff[IDX_W'(top_ch)]) begin
                  dl_we      = 1'b1;
                  dl_widx    = IDX_W'(top_ch);
                  dl_wdata   = count_ff + period_ff[IDX_W'(top_ch)];
                  pend_ch_in = top_ch;
                  pend_dl_in = dl_wdata;
                  state_in   = S_ARM;
               end else if (due_n_ff == CNT_W'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_ARM: begin
            qop        = '{code: tdvt_pkg::QOP_INSERT, ch: pend_ch_ff};
            armed_we   = 1'b1;
            armed_wval = 1'b1;
            armed_widx = pend_idx;
            state_in   = (due_n_ff == '0) ? S_IDLE : S_EMIT;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         due_n_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_TIMERS; i++) begin
            armed_ff[i] <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         due_n_ff     <= due_n_in;
         rsp_valid_ff <= rsp_valid_in;
         if (armed_we) begin
            armed_ff[armed_widx] <= armed_wval;
         end
      end
      pend_ch_ff  <= pend_ch_in;
      pend_dl_ff  <= pend_dl_in;
      q_ok_ff     <= q_ok_in;
      q_rem_ff    <= q_rem_in;
      rsp_data_ff <= rsp_data_in;
      if (dl_we) begin
         deadline_ff[dl_widx] <= dl_wdata;
      end
      if (cfg_we) begin
         period_ff[req_idx] <= per_wdata;
         single_ff[req_idx] <= req_data.one_shot;
      end
      if (due_we) begin
         due_ff[due_n_ff[IDX_W-1:0]] <= head_ch;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `TDVT_ASSERT_NEXT(a_tick_advance, accept && (req_data.command == tdvt_pkg::CMD_TICK), count_ff == $past(count_ff) + COUNT_WIDTH'(1), "tick did not advance the counter")
   `TDVT_ASSERT_NOW(a_insert_room, qop.code == tdvt_pkg::QOP_INSERT, !q_full, "insert into a full queue")
   `TDVT_ASSERT_NOW(a_due_bound, 1'b1, due_n_ff <= CNT_W'(NUM_TIMERS), "due stack overflow")
   `TDVT_ASSERT_NEXT(a_last_report, (state_ff == S_EMIT) && out_free && (due_n_ff == CNT_W'(1)), rsp_valid_ff && rsp_data_ff.last, "final expiry report not marked last")

endmodule

>>> bench/tb_top.sv
// Self-checking bench for the tick driven virtual timer bank.
// Depends on tdvt_pkg and tick_driven_virtual_timer_bank; predicts every
// expiry report and query reply and compares each result transfer in order.
`timescale 1ns / 1ps

module tb_top;

   localparam int NT = 16;
   localparam logic [31:0] MAX_PER = 32'h8000_0000;
   localparam logic [31:0] HALF = 32'h7FFF_FFFF;
   localparam logic [2:0] CMD_BAD = 3'd5;
   localparam logic [2:0] CMD_BAD_TOP = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   tdvt_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   tdvt_pkg::rsp_type rsp_data;

   tick_driven_virtual_timer_bank u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // predicted timer bank state
   logic [31:0] now_count;
   logic [31:0] due_at [NT];
   logic [31:0] per_of [NT];
   logic        is_armed [NT];
   logic        is_single [NT];
   logic [3:0]  deadline_order [$];

   tdvt_pkg::rsp_type expected_results [$];
   int errors = 0;
   int results_seen = 0;
   int expiries_seen = 0;
   int items_sent = 0;

   function automatic void queue_insert(logic [3:0] ch);
      int pos;
      logic [31:0] d;
      pos = 0;
      while (pos < deadline_order.size()) begin
         d = due_at[deadline_order[pos]] - due_at[ch];
         if (d < HALF) break;
         pos++;
      end
      deadline_order.insert(pos, ch);
   endfunction

   function automatic void arm_channel(logic [3:0] ch);
      due_at[ch] = now_count + per_of[ch];
      queue_insert(ch);
      is_armed[ch] = 1'b1;
   endfunction

   function automatic void predict_item(tdvt_pkg::req_type r);
      logic [3:0] due [$];
      logic [31:0] p;
      tdvt_pkg::rsp_type e;
      case (r.command)
         tdvt_pkg::CMD_TICK: begin
            now_count = now_count + 32'd1;
            while (deadline_order.size() > 0 && due_at[deadline_order[0]] == now_count)
               due.push_back(deadline_order.pop_front());
            // report in reverse of pull order: oldest armed first
            for (int k = 0; k < due.size(); k++) begin
               logic [3:0] c;
               c = due[due.size() - 1 - k];
               e.kind = tdvt_pkg::KIND_EXPIRY;
               e.channel_out = c;
               e.elapsed = '0;
               e.last = (k == due.size() - 1);
               expected_results.push_back(e);
               is_armed[c] = 1'b0;
               if (!is_single[c]) arm_channel(c);
            end
         end
         tdvt_pkg::CMD_START: begin
            if (!is_armed[r.channel]) begin
               p = r.period;
               if (p == 0) p = 1;
               if (p > MAX_PER) p = MAX_PER;
               per_of[r.channel] = p;
               is_single[r.channel] = r.one_shot;
               arm_channel(r.channel);
            end
         end
         tdvt_pkg::CMD_STOP, tdvt_pkg::CMD_RESTART: begin
            if (is_armed[r.channel]) begin
               is_armed[r.channel] = 1'b0;
               foreach (deadline_order[i])
                  if (deadline_order[i] == r.channel) begin
                     deadline_order.delete(i);
                     break;
                  end
               if (r.command == tdvt_pkg::CMD_RESTART) arm_channel(r.channel);
            end
         end
         tdvt_pkg::CMD_QUERY: begin
            e.kind = tdvt_pkg::KIND_QUERY;
            e.channel_out = r.channel;
            e.elapsed = is_armed[r.channel] ?
               per_of[r.channel] - (due_at[r.channel] - now_count) : '0;
            e.last = 1'b1;
            expected_results.push_back(e);
         end
         default: ;
      endcase
   endfunction

   // sender: bursts with random gaps
   int burst_left = 0;

   task automatic send_item(tdvt_pkg::req_type r);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 2) != 0) begin
            // drop valid for the gap between bursts
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
      end
      burst_left--;
      req_data <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      predict_item(r);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_cmd(logic [2:0] c, logic [3:0] ch, logic [31:0] p, logic os);
      tdvt_pkg::req_type r;
      r.command = c;
      r.channel = ch;
      r.period = p;
      r.one_shot = os;
      send_item(r);
   endtask

   task automatic ticks(int n);
      repeat (n) send_cmd(tdvt_pkg::CMD_TICK, 4'($urandom()), $urandom(), 1'($urandom()));
   endtask

   // receiver: stall pattern of its own, with calm stretches
   initial begin
      int mode;
      @(negedge clock);
      forever begin
         mode = $urandom_range(0, 3);
         repeat ($urandom_range(5, 40)) begin
            rsp_stall <= (mode == 0) ? 1'b0 : ($urandom_range(0, mode) == 0);
            @(negedge clock);
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      tdvt_pkg::rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result %p", $realtime, rsp_data);
            errors++;
         end else begin
            e = expected_results.pop_front();
            if (e.kind == tdvt_pkg::KIND_EXPIRY) expiries_seen++;
            if (rsp_data.kind !== e.kind) begin
               $display("%0t: kind exp %0d got %0d", $realtime, e.kind, rsp_data.kind);
               errors++;
            end
            if (rsp_data.channel_out !== e.channel_out) begin
               $display("%0t: channel exp %0d got %0d", $realtime, e.channel_out,
                        rsp_data.channel_out);
               errors++;
            end
            if (rsp_data.elapsed !== e.elapsed) begin
               $display("%0t: elapsed exp %0h got %0h", $realtime, e.elapsed,
                        rsp_data.elapsed);
               errors++;
            end
            if (rsp_data.last !== e.last) begin
               $display("%0t: last exp %0d got %0d", $realtime, e.last, rsp_data.last);
               errors++;
            end
         end
      end
   end

   task automatic test_basic_commands();
      send_cmd(tdvt_pkg::CMD_QUERY, 4'd0, 32'd0, 1'b0);          // idle query
      send_cmd(tdvt_pkg::CMD_START, 4'd0, 32'd0, 1'b1);          // zero period clamps
      send_cmd(tdvt_pkg::CMD_START, 4'd1, 32'hFFFF_FFFF, 1'b0);  // over-long period clamps
      send_cmd(tdvt_pkg::CMD_START, 4'd15, 32'd3, 1'b0);
      send_cmd(tdvt_pkg::CMD_START, 4'd15, 32'd9, 1'b1);         // already armed: ignored
      send_cmd(tdvt_pkg::CMD_QUERY, 4'd1, 32'd0, 1'b0);
      ticks(1);
      send_cmd(tdvt_pkg::CMD_QUERY, 4'd15, 32'd0, 1'b0);
      send_cmd(tdvt_pkg::CMD_STOP, 4'd7, 32'd0, 1'b0);           // stop idle: ignored
      send_cmd(tdvt_pkg::CMD_RESTART, 4'd8, 32'd0, 1'b0);        // restart idle: ignored
      send_cmd(CMD_BAD, 4'd2, 32'd5, 1'b1);
      send_cmd(CMD_BAD_TOP, 4'd2, 32'd5, 1'b1);
      send_cmd(tdvt_pkg::CMD_RESTART, 4'd15, 32'd0, 1'b0);
      ticks(4);
      send_cmd(tdvt_pkg::CMD_STOP, 4'd15, 32'd0, 1'b0);
      send_cmd(tdvt_pkg::CMD_STOP, 4'd1, 32'd0, 1'b0);
   endtask

   task automatic test_equal_deadlines();
      // every channel due on the same tick
      for (int c = 0; c < NT; c++) send_cmd(tdvt_pkg::CMD_START, c[3:0], 32'd2, c[0]);
      ticks(2);
      send_cmd(tdvt_pkg::CMD_QUERY, 4'd2, 32'd0, 1'b0);
      ticks(2);
      for (int c = 0; c < NT; c++) send_cmd(tdvt_pkg::CMD_STOP, c[3:0], 32'd0, 1'b0);
   endtask

   task automatic test_random_mix();
      int op;
      logic [31:0] p;
      for (int i = 0; i < 175; i++) begin
         op = $urandom_range(0, 99);
         case ($urandom_range(0, 9))
            0: p = $urandom();
            1: p = 32'd0;
            2: p = MAX_PER + $urandom_range(0, 3);
            default: p = $urandom_range(1, 6);
         endcase
         if (op < 45) ticks(1);
         else if (op < 65)
            send_cmd(tdvt_pkg::CMD_START, 4'($urandom()), p, 1'($urandom()));
         else if (op < 72)
            send_cmd(tdvt_pkg::CMD_STOP, 4'($urandom()), $urandom(), 1'($urandom()));
         else if (op < 80)
            send_cmd(tdvt_pkg::CMD_RESTART, 4'($urandom()), $urandom(), 1'($urandom()));
         else if (op < 97)
            send_cmd(tdvt_pkg::CMD_QUERY, 4'($urandom()), $urandom(), 1'($urandom()));
         else
            send_cmd(3'($urandom_range(CMD_BAD, CMD_BAD_TOP)), 4'($urandom()), $urandom(),
                     1'($urandom()));
      end
   endtask

   initial begin
      now_count = '0;
      for (int c = 0; c < NT; c++) begin
         due_at[c] = '0;
         per_of[c] = '0;
         is_armed[c] = 1'b0;
         is_single[c] = 1'b0;
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_basic_commands();
      test_equal_deadlines();
      test_random_mix();
      req_valid <= 1'b0;
      wait (expected_results.size() == 0);
      repeat (100) @(posedge clock);
      $display("Covered %0d commands, %0d results of which %0d expiry reports.",
               items_sent, results_seen, expiries_seen);
      if (errors == 0 && expected_results.size() == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

   initial begin
      #3ms;
      $display("tb_top: FAIL");
      $finish;
   end

endmodule
